[hdl/ibwt_pkg.sv]
// shared types and constants for the inverse bwt lf-mapping block
// no dependencies; compiled first
package ibwt_pkg;

  localparam int DEF_BLOCK_LEN   = 64;
  localparam int DEF_SYMBOL_BITS = 8;

  // fixed field widths of the stream payloads
  localparam int SYM_W     = 9;
  localparam int SYM_LOW_W = 8;
  localparam int STATUS_W  = 2;

  localparam logic [STATUS_W-1:0] STAT_COMPLETE = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_SENT  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

  localparam logic signed [SYM_W-1:0] SENT_SYMBOL = '1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_PREFIX,
    S_PREFIX_LAST,
    S_WALK_CHK,
    S_WALK_NEXT,
    S_EMIT_RD,
    S_EMIT_LOAD,
    S_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic signed [SYM_W-1:0] out_symbol;
    logic [STATUS_W-1:0]     status;
    logic                    run_end;
  } result_t;

endpackage

[hdl/ibwt_in_if.sv]
// input stream channel: bwt column symbols with block end mark
// depends on ibwt_pkg
interface ibwt_in_if;
  import ibwt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SYM_W-1:0] symbol;
  logic                    block_end;

  modport source(output valid, symbol, block_end, input ready);
  modport sink(input valid, symbol, block_end, output ready);
endinterface

[hdl/ibwt_out_if.sv]
// output stream channel: decoded symbols with status and run end mark
// depends on ibwt_pkg
interface ibwt_out_if;
  import ibwt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SYM_W-1:0] out_symbol;
  logic [STATUS_W-1:0]     status;
  logic                    run_end;

  modport source(output valid, out_symbol, status, run_end, input ready);
  modport sink(input valid, out_symbol, status, run_end, output ready);
endinterface

[hdl/ibwt_alu.sv]
// shared adder with limit compare, used for count update, prefix sum and lf row
// depends on ibwt_pkg for the default width only
module ibwt_alu #(
  parameter int LEN_W = $clog2(ibwt_pkg::DEF_BLOCK_LEN + 1)
) (
  input  logic [LEN_W-1:0] a,
  input  logic [LEN_W-1:0] b,
  input  logic [LEN_W-1:0] limit,
  output logic [LEN_W:0]   sum,
  output logic             at_limit
);

  assign sum      = {1'b0, a} + {1'b0, b};
  assign at_limit = sum >= {1'b0, limit};

endmodule

[hdl/ibwt_out_stage.sv]
// output register stage holding one result until the sink takes it
// depends on ibwt_pkg and ibwt_out_if
module ibwt_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ibwt_pkg::result_t data,
  output logic             busy,
  ibwt_out_if.source       dst
);
  import ibwt_pkg::*;

  logic    valid;
  result_t hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (dst.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= data;
    end
  end

  assign dst.valid      = valid;
  assign dst.out_symbol = hold.out_symbol;
  assign dst.status     = hold.status;
  assign dst.run_end    = hold.run_end;
  assign busy           = valid;

endmodule

[hdl/inverse_bwt_lf_mapping.sv]
// top level: inverse bwt by lf-mapping, one block at a time
// depends on ibwt_pkg, ibwt_in_if, ibwt_out_if, ibwt_alu, ibwt_out_stage
//
// in_ch carries one bwt column symbol per transfer (negative = sentinel);
// block_end marks the last symbol of a block. Each symbol takes a count
// read, then a count/rank write, and in_ch.ready is low during the write,
// so a new symbol waits until the last one is written; a symbol past
// BLOCK_LEN is dropped. After block_end the block builds first-column
// offsets over the alphabet through the count memory port, then walks the
// lf-mapping, each row a column read then an offset read, and emits the
// decoded run on out_ch, newest walk symbol first, closed by the sentinel
// with run_end set. The output register holds a result until out_ch.ready
// takes it, and the emit states wait meanwhile.
// in_ch.ready stays low from block_end until the sentinel result has been taken.
// status: 0 complete, 1 short run, 2 no sentinel met (walk capped at block
// length), 3 more than BLOCK_LEN symbols sent (extra symbols dropped).
// After reset the symbol count memory is cleared with in_ch.ready low;
// later blocks clear it during the offset pass.
module inverse_bwt_lf_mapping #(
  parameter int BLOCK_LEN   = ibwt_pkg::DEF_BLOCK_LEN,
  parameter int SYMBOL_BITS = ibwt_pkg::DEF_SYMBOL_BITS
) (
  input  logic       clk,
  input  logic       rst,
  ibwt_in_if.sink    in_ch,
  ibwt_out_if.source out_ch
);
  import ibwt_pkg::*;

  localparam int ALPHA = (1 << SYMBOL_BITS) + 1;
  localparam int IW    = SYMBOL_BITS + 1;
  localparam int LW    = $clog2(BLOCK_LEN + 1);
  localparam int RW    = $clog2(BLOCK_LEN);
  localparam logic [IW-1:0] AL_LAST = IW'(ALPHA - 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(BLOCK_LEN);
  localparam logic [SYM_LOW_W-1:0] LOW_MASK =
    (SYMBOL_BITS >= SYM_LOW_W) ? '1 : SYM_LOW_W'((1 << SYMBOL_BITS) - 1);

  state_t state, state_next;

  logic [IW-1:0]       idx_in, idx_reg, alpha_addr, pre_addr_d;
  logic                last_reg, pre_valid, overflow, run_done;
  logic [LW-1:0]       len_cnt, sum, n_cnt, emit_cnt, emit_m1;
  logic [RW-1:0]       rank_reg;
  logic [STATUS_W-1:0] status_reg;
  logic [LW:0]         n_inc;
  logic                n_ge, walk_stop;

  // memories
  logic [LW-1:0] cnt_mem [ALPHA];
  logic [LW-1:0] off_mem [ALPHA];
  logic [IW-1:0] col_mem [BLOCK_LEN];
  logic [RW-1:0] rank_mem [BLOCK_LEN];
  logic [IW-1:0] dec_mem [BLOCK_LEN];

  logic          cnt_we, off_we, col_we, dec_we;
  logic [IW-1:0] cnt_waddr, cnt_raddr;
  logic [LW-1:0] cnt_wdata, cnt_rd, off_rd;
  logic [RW-1:0] col_raddr, dec_raddr;
  logic [IW-1:0] col_rd, dec_rd, dec_m1;
  logic [RW-1:0] rank_rd;

  // shared unit
  logic [LW-1:0] alu_a, alu_b, alu_limit;
  logic [LW:0]   alu_sum;
  logic          alu_at_limit;

  logic    out_load, out_busy;
  result_t out_data;

  ibwt_alu #(.LEN_W(LW)) u_alu (
    .a        (alu_a),
    .b        (alu_b),
    .limit    (alu_limit),
    .sum      (alu_sum),
    .at_limit (alu_at_limit)
  );

  ibwt_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .data (out_data),
    .busy (out_busy),
    .dst  (out_ch)
  );

  // any negative symbol is the sentinel, alphabet index 0
  assign idx_in = in_ch.symbol[SYM_W-1] ? '0
                : IW'(in_ch.symbol[SYM_LOW_W-1:0] & LOW_MASK) + IW'(1);

  assign n_inc     = {1'b0, n_cnt} + (LW + 1)'(1);
  assign n_ge      = n_inc >= {1'b0, len_cnt};
  assign walk_stop = (col_rd == '0) || n_ge;
  assign emit_m1   = emit_cnt - LW'(1);
  assign dec_raddr = emit_m1[RW-1:0];
  assign dec_m1    = dec_rd - IW'(1);
  assign col_we    = (state == S_LOAD);
  assign off_we    = ((state == S_PREFIX) && pre_valid) || (state == S_PREFIX_LAST);

  always_comb begin
    out_data.out_symbol = (state == S_EMIT_RD) ? SENT_SYMBOL : $signed(SYM_W'(dec_m1));
    out_data.status     = status_reg;
    out_data.run_end    = (state == S_EMIT_RD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    cnt_we      = 1'b0;
    cnt_waddr   = alpha_addr;
    cnt_wdata   = '0;
    cnt_raddr   = idx_in;
    alu_a       = sum;
    alu_b       = cnt_rd;
    alu_limit   = len_cnt;
    col_raddr   = '0;
    dec_we      = 1'b0;
    out_load    = 1'b0;
    case (state)
      S_CLEAR: begin
        cnt_we = 1'b1;
        if (alpha_addr == AL_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (len_cnt < LEN_MAX) begin
            state_next = S_LOAD;
          end else if (in_ch.block_end) begin
            state_next = S_PREFIX;
          end
        end
      end
      S_LOAD: begin
        alu_a      = cnt_rd;
        alu_b      = LW'(1);
        cnt_we     = 1'b1;
        cnt_waddr  = idx_reg;
        cnt_wdata  = alu_sum[LW-1:0];
        state_next = last_reg ? S_PREFIX : S_IDLE;
      end
      S_PREFIX: begin
        // read one count ahead, clear the one whose offset is written now
        cnt_raddr = alpha_addr;
        cnt_we    = pre_valid;
        cnt_waddr = pre_addr_d;
        if (alpha_addr == AL_LAST) begin
          state_next = S_PREFIX_LAST;
        end
      end
      S_PREFIX_LAST: begin
        cnt_we     = 1'b1;
        cnt_waddr  = pre_addr_d;
        state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        dec_we     = !walk_stop;
        state_next = walk_stop ? S_EMIT_RD : S_WALK_NEXT;
      end
      S_WALK_NEXT: begin
        alu_a      = off_rd;
        alu_b      = LW'(rank_reg);
        col_raddr  = alu_at_limit ? '0 : alu_sum[RW-1:0];
        state_next = S_WALK_CHK;
      end
      S_EMIT_RD: begin
        if (emit_cnt == '0) begin
          out_load   = 1'b1;
          state_next = S_EMIT_WAIT;
        end else begin
          state_next = S_EMIT_LOAD;
        end
      end
      S_EMIT_LOAD: begin
        out_load   = 1'b1;
        state_next = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (!out_busy) begin
          state_next = run_done ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_cnt    <= '0;
      overflow   <= 1'b0;
      alpha_addr <= '0;
      pre_valid  <= 1'b0;
      run_done   <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          alpha_addr <= alpha_addr + IW'(1);
        end
        S_IDLE: begin
          alpha_addr <= '0;
          sum        <= '0;
          pre_valid  <= 1'b0;
          run_done   <= 1'b0;
          if (in_ch.valid) begin
            idx_reg  <= idx_in;
            last_reg <= in_ch.block_end;
            if (len_cnt >= LEN_MAX) begin
              overflow <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          len_cnt <= len_cnt + LW'(1);
        end
        S_PREFIX: begin
          alpha_addr <= alpha_addr + IW'(1);
          pre_addr_d <= alpha_addr;
          pre_valid  <= 1'b1;
          if (pre_valid) begin
            sum <= alu_sum[LW-1:0];
          end
        end
        S_PREFIX_LAST: begin
          n_cnt <= '0;
        end
        S_WALK_CHK: begin
          rank_reg <= rank_rd;
          if (walk_stop) begin
            emit_cnt <= n_cnt;
            if (overflow) begin
              status_reg <= STAT_OVERFLOW;
            end else if (col_rd != '0) begin
              status_reg <= STAT_NO_SENT;
            end else if (!n_ge) begin
              status_reg <= STAT_SHORT;
            end else begin
              status_reg <= STAT_COMPLETE;
            end
          end else begin
            n_cnt <= n_cnt + LW'(1);
          end
        end
        S_EMIT_RD: begin
          if (emit_cnt == '0) begin
            run_done <= 1'b1;
          end
        end
        S_EMIT_LOAD: begin
          emit_cnt <= emit_m1;
        end
        S_EMIT_WAIT: begin
          if (!out_busy && run_done) begin
            len_cnt  <= '0;
            overflow <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // symbol counts
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd <= cnt_mem[cnt_raddr];
  end

  // first-column offsets
  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[pre_addr_d] <= sum;
    end
    off_rd <= off_mem[col_rd];
  end

  // bwt column and running rank
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[len_cnt[RW-1:0]]  <= idx_reg;
      rank_mem[len_cnt[RW-1:0]] <= cnt_rd[RW-1:0];
    end
    col_rd  <= col_mem[col_raddr];
    rank_rd <= rank_mem[col_raddr];
  end

  // decoded symbols in walk order
  always_ff @(posedge clk) begin
    if (dec_we) begin
      dec_mem[n_cnt[RW-1:0]] <= col_rd;
    end
    dec_rd <= dec_mem[dec_raddr];
  end

endmodule
